/* src/cmfta_pkg.sv */
// Package: shared types and constants for the cube map face texel address block.
`default_nettype none
package cmfta_pkg;
  localparam int DirWidth  = 24;
  localparam int SizeBits  = 12;
  localparam int DimWidth  = SizeBits + 1;
  localparam int NumWidth  = DirWidth + 1;
  localparam int ProdWidth = NumWidth + DimWidth;

  localparam logic [1:0] CfgSkybox = 2'd0;
  localparam logic [1:0] CfgWidth  = 2'd1;
  localparam logic [1:0] CfgHeight = 2'd2;

  localparam logic [DimWidth-1:0] DimReset = DimWidth'(1024);

  typedef enum logic [1:0] {
    ST_TEXEL = 2'd0,
    ST_FLAT  = 2'd1,
    ST_BLACK = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    FACE_RIGHT  = 3'd0,
    FACE_LEFT   = 3'd1,
    FACE_TOP    = 3'd2,
    FACE_BOTTOM = 3'd3,
    FACE_FRONT  = 3'd4,
    FACE_BACK   = 3'd5
  } face_e;

  typedef struct packed {
    logic signed [DirWidth-1:0] dir_x;
    logic signed [DirWidth-1:0] dir_y;
    logic signed [DirWidth-1:0] dir_z;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [2:0]          face;
    logic [SizeBits-1:0] column;
    logic [SizeBits-1:0] row;
  } out_beat_t;

  typedef struct packed {
    status_e             status;
    face_e               face;
    logic [NumWidth-1:0] num_col;
    logic [NumWidth-1:0] num_row;
    logic [NumWidth-1:0] den;
  } work_t;
endpackage
`default_nettype wire

/* src/cmfta_front.sv */
// Front end: picks the major axis and face, forms the rational face coordinates.
`default_nettype none
module cmfta_front (
  input  cmfta_pkg::in_beat_t beat_i,
  input  logic                skybox_i,
  output cmfta_pkg::work_t    work_o
);
  import cmfta_pkg::*;

  logic [DirWidth-1:0]        ax, ay, az, a;
  logic signed [DirWidth+1:0] xs, ys, zs, as_, nu, nv;
  logic                       sel_x, sel_y;
  face_e                      face;
  logic [NumWidth-1:0]        den;

  always_comb begin
    xs = {{2{beat_i.dir_x[DirWidth-1]}}, beat_i.dir_x};
    ys = {{2{beat_i.dir_y[DirWidth-1]}}, beat_i.dir_y};
    zs = {{2{beat_i.dir_z[DirWidth-1]}}, beat_i.dir_z};
    ax = beat_i.dir_x[DirWidth-1] ? DirWidth'(-beat_i.dir_x) : beat_i.dir_x;
    ay = beat_i.dir_y[DirWidth-1] ? DirWidth'(-beat_i.dir_y) : beat_i.dir_y;
    az = beat_i.dir_z[DirWidth-1] ? DirWidth'(-beat_i.dir_z) : beat_i.dir_z;
    sel_x = (ax >= ay) && (ax >= az);
    sel_y = (ay >= ax) && (ay >= az);
    if (sel_x) begin
      a    = ax;
      as_  = {2'b00, ax};
      face = (!beat_i.dir_x[DirWidth-1] && (|beat_i.dir_x)) ? FACE_RIGHT : FACE_LEFT;
      nu   = (face == FACE_RIGHT) ? as_ - zs : as_ + zs;
      nv   = as_ + ys;
    end else if (sel_y) begin
      a    = ay;
      as_  = {2'b00, ay};
      face = (!beat_i.dir_y[DirWidth-1] && (|beat_i.dir_y)) ? FACE_TOP : FACE_BOTTOM;
      nu   = as_ + xs;
      nv   = as_ - zs;
    end else begin
      a    = az;
      as_  = {2'b00, az};
      face = (!beat_i.dir_z[DirWidth-1] && (|beat_i.dir_z)) ? FACE_FRONT : FACE_BACK;
      nu   = (face == FACE_FRONT) ? as_ + xs : as_ - xs;
      nv   = as_ + ys;
    end
    den = {a, 1'b0};
    work_o.face    = face;
    work_o.den     = den;
    work_o.num_col = nu[NumWidth-1:0];
    work_o.num_row = den - nv[NumWidth-1:0];
    if (!skybox_i) begin
      work_o.status = ST_FLAT;
    end else if (a == '0) begin
      work_o.status = ST_BLACK;
    end else begin
      work_o.status = ST_TEXEL;
    end
  end
endmodule
`default_nettype wire

/* src/cmfta_fifo.sv */
// Two-entry queue between the front end and the divider pipeline.
`default_nettype none
module cmfta_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  cmfta_pkg::work_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output cmfta_pkg::work_t data_o
);
  import cmfta_pkg::*;

  work_t      mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = do_push ? !wr_q : wr_q;
    rd_d  = do_pop ? !rd_q : rd_q;
    cnt_d = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q != 2'd3)
    else $error("queue count out of range");
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q == 2'd0 |-> !do_pop)
    else $error("pop from empty queue");
  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 2'd1)
    else $error("queue count lost a push");
endmodule
`default_nettype wire

/* src/cmfta_back.sv */
// Back end: multiply, bit-serial pipelined divide, wrap, and output register.
`default_nettype none
module cmfta_back (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  cmfta_pkg::work_t                      work_i,
  output logic                                  pop_o,
  input  logic [cmfta_pkg::DimWidth-1:0]        width_i,
  input  logic [cmfta_pkg::DimWidth-1:0]        height_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output cmfta_pkg::out_beat_t                  out_beat_o
);
  import cmfta_pkg::*;

  localparam int Stages = DimWidth;

  typedef struct packed {
    status_e              status;
    face_e                face;
    logic [NumWidth-1:0]  den;
    logic [ProdWidth-1:0] rem_c;
    logic [ProdWidth-1:0] rem_r;
    logic [DimWidth-1:0]  q_c;
    logic [DimWidth-1:0]  q_r;
  } stage_t;

  stage_t    stg_q [Stages+1];
  logic      vld_q [Stages+1];
  logic      en;
  logic      out_valid_q;
  out_beat_t out_q, out_d;
  logic [DimWidth-1:0] wm1, hm1;

  assign en          = !(out_valid_q && out_stall_i);
  assign pop_o       = en && valid_i;
  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_q;
  assign wm1         = width_i - DimWidth'(1);
  assign hm1         = height_i - DimWidth'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      stg_q[0].status <= work_i.status;
      stg_q[0].face   <= work_i.face;
      stg_q[0].den    <= work_i.den;
      stg_q[0].rem_c  <= ProdWidth'(work_i.num_col) * ProdWidth'(wm1);
      stg_q[0].rem_r  <= ProdWidth'(work_i.num_row) * ProdWidth'(hm1);
      stg_q[0].q_c    <= '0;
      stg_q[0].q_r    <= '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= valid_i;
    end
  end

  for (genvar i = 0; i < Stages; i++) begin : g_div
    logic [ProdWidth-1:0] dsh;
    logic                 ge_c, ge_r;
    assign dsh  = ProdWidth'(stg_q[i].den) << (Stages - 1 - i);
    assign ge_c = stg_q[i].rem_c >= dsh;
    assign ge_r = stg_q[i].rem_r >= dsh;

    always_ff @(posedge clk_i) begin
      if (en) begin
        stg_q[i+1].status <= stg_q[i].status;
        stg_q[i+1].face   <= stg_q[i].face;
        stg_q[i+1].den    <= stg_q[i].den;
        stg_q[i+1].rem_c  <= ge_c ? stg_q[i].rem_c - dsh : stg_q[i].rem_c;
        stg_q[i+1].rem_r  <= ge_r ? stg_q[i].rem_r - dsh : stg_q[i].rem_r;
        stg_q[i+1].q_c    <= {stg_q[i].q_c[DimWidth-2:0], ge_c};
        stg_q[i+1].q_r    <= {stg_q[i].q_r[DimWidth-2:0], ge_r};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en) begin
        vld_q[i+1] <= vld_q[i];
      end
    end
  end

  function automatic logic [SizeBits-1:0] wrap_index(logic [DimWidth-1:0] q,
                                                     logic [DimWidth-1:0] size);
    logic [DimWidth:0] c;
    c = {1'b0, q} + (DimWidth+1)'(1);
    if (size == '0 || c >= {1'b0, size}) begin
      return '0;
    end
    return c[SizeBits-1:0];
  endfunction

  always_comb begin
    out_d        = '0;
    out_d.status = stg_q[Stages].status;
    if (stg_q[Stages].status == ST_TEXEL) begin
      out_d.face   = stg_q[Stages].face;
      out_d.column = wrap_index(stg_q[Stages].q_c, width_i);
      out_d.row    = wrap_index(stg_q[Stages].q_r, height_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Stages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  a_flat_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_TEXEL |->
      out_q.face == '0 && out_q.column == '0 && out_q.row == '0)
    else $error("non-texel beat carries address");
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && vld_q[0] |=> vld_q[1])
    else $error("divider stage dropped a beat");
  a_face_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.face <= 3'd5 && out_q.status != 2'd3)
    else $error("bad face or status");
endmodule
`default_nettype wire

/* src/cube_map_face_texel_address_top.sv */
// Top level: cube map face texel address block with configuration registers.
// Takes one direction beat per cycle while in_stall_o is low and returns one address
// beat per beat, in order. The beat lands in the two-entry queue at the accepting
// edge, then takes one multiply stage, 13 divider stages (one quotient bit each,
// column and row in parallel) and the output register. Configuration writes are
// always ready and take effect at once, so write them only while no beat is in
// flight.
`default_nettype none
module cube_map_face_texel_address_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  cmfta_pkg::in_beat_t                  in_beat_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output cmfta_pkg::out_beat_t                 out_beat_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [1:0]                           cfg_index_i,
  input  logic [cmfta_pkg::DimWidth-1:0]       cfg_data_i
);
  import cmfta_pkg::*;

  logic                skybox_q;
  logic [DimWidth-1:0] width_q, height_q;
  work_t               front_work, head_work;
  logic                full, head_valid, pop;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skybox_q <= 1'b0;
      width_q  <= DimReset;
      height_q <= DimReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgSkybox: skybox_q <= cfg_data_i[0];
        CfgWidth:  width_q  <= cfg_data_i;
        CfgHeight: height_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  cmfta_front u_front (
    .beat_i   (in_beat_i),
    .skybox_i (skybox_q),
    .work_o   (front_work)
  );

  cmfta_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (front_work),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (head_valid),
    .data_o  (head_work)
  );

  cmfta_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (head_valid),
    .work_i      (head_work),
    .pop_o       (pop),
    .width_i     (width_q),
    .height_i    (height_q),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );
endmodule
`default_nettype wire
